// File: rtl/core/kvi_pkg.sv
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared types and constants for the keyframe vec3 interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int MAX_KEYS_DEFAULT = 256;
  localparam int KC_W   = 9;   // key_count register width
  localparam int CNT_W  = 13;  // wide enough to hold any key count up to 4096
  localparam int VAL_W  = 32;
  localparam int DIFF_W = 33;
  localparam int DVD_W  = 48;  // |elapsed| << 16
  localparam int FAC_W  = 49;  // factor magnitude, up to 2^48
  localparam int FAC_LO = 24;  // low slice of the factor for the split multiply
  localparam int PRD_W  = 82;  // full product width
  localparam int DIV_CNT_W = 6;

  localparam logic [FAC_W-1:0] FACTOR_SAT = FAC_W'(1) << 48;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_KEY_COUNT = 1'b0;  // paddr[2]

  typedef struct packed {
    logic        [31:0] time_val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } key_entry_t;

  typedef struct packed {
    logic             start;
    logic             fneg;
    logic [FAC_W-1:0] mf;
  } lerp_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } lerp_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE,
    S_SCAN,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_PREP,
    S_DIV,
    S_LERP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    LP_IDLE,
    LP_ABS,
    LP_LO,
    LP_HI,
    LP_ACC,
    LP_SAT
  } lerp_phase_t;

endpackage

// File: rtl/core/keyframe_vec3_interpolator_core.sv
// ----------------------------------------------------------------------------
// keyframe_vec3_interpolator_core
// Keyframe table with linear-search lookup and vec3 linear interpolation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): command 0 writes key_index with key_time
// and key_x/y/z in the beat it is accepted and makes no result. Command 1
// queries query_time and makes one output beat (out_x/y/z, segment, fault).
// Queries run one at a time; in_stall stays high until the result is in the
// output register. A query steps through the scan reads, the key fetch, the
// setup state, the 48-step divider and the two-slice multiplier for each
// component, then hands its result over to the output register. A zero-length
// segment skips the divider. A single-key query skips the search and the
// arithmetic. Writes never stall the input. While out_stall holds a result, a
// finished query waits for the output register and the input stays stalled.
// key_count is set over the APB port at byte 0 (reset value 1). The table
// holds garbage after reset until written. Reset clears all control state.
// ----------------------------------------------------------------------------
module keyframe_vec3_interpolator_core #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [7:0]         key_index,
  input  logic [31:0]        key_time,
  input  logic signed [31:0] key_x,
  input  logic signed [31:0] key_y,
  input  logic signed [31:0] key_z,
  input  logic [31:0]        query_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [7:0]         segment,
  output logic               fault
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = kvi_pkg::CNT_W;

  kvi_pkg::state_t state, state_next;

  logic [kvi_pkg::KC_W-1:0] key_count;
  logic [CW-1:0]            n_keys;
  logic [AW-1:0]            n1;

  logic                     accept;
  logic                     wr_en;
  logic [CW-1:0]            ki_ext;
  kvi_pkg::key_entry_t      wr_data;
  logic [AW-1:0]            rd_addr;
  kvi_pkg::key_entry_t      rd_data;

  logic [31:0]              qtime;
  logic [AW-1:0]            pv_addr;
  logic [AW-1:0]            seg;
  kvi_pkg::key_entry_t      k0;
  kvi_pkg::key_entry_t      k1;
  logic signed [32:0]       el;
  logic signed [32:0]       dt;
  logic [32:0]              el_mag;
  logic [32:0]              dt_mag;
  logic [kvi_pkg::FAC_W-1:0] mf;
  logic                     fneg;
  logic                     fault_acc;
  logic [1:0]               comp;
  logic                     lerp_go;
  logic signed [31:0]       res_x, res_y, res_z;
  logic                     load_out;
  logic                     found;

  logic                      div_start;
  logic                      div_done;
  logic [kvi_pkg::DVD_W-1:0] div_q;

  kvi_pkg::lerp_req_t       lerp_req;
  kvi_pkg::lerp_rsp_t       lerp_rsp;
  logic signed [31:0]       lerp_a, lerp_b, lerp_res;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == kvi_pkg::REG_KEY_COUNT) ? 32'(key_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kvi_pkg::KC_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == kvi_pkg::REG_KEY_COUNT) begin
      key_count <= pwdata[kvi_pkg::KC_W-1:0];
    end
  end

  always_comb begin
    if (key_count == '0) begin
      n_keys = CW'(1);
    end else if (CW'(key_count) > CW'(MAX_KEYS)) begin
      n_keys = CW'(MAX_KEYS);
    end else begin
      n_keys = CW'(key_count);
    end
  end
  assign n1 = AW'(n_keys - CW'(1));

  // Table
  assign in_stall = (state != kvi_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ki_ext   = CW'(key_index);
  assign wr_en    = accept && command == kvi_pkg::CMD_WRITE && ki_ext < CW'(MAX_KEYS);
  assign wr_data  = '{time_val: key_time, x: key_x, y: key_y, z: key_z};

  kvi_key_mem #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ki_ext[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign el_mag = el[32] ? 33'(-el) : 33'(el);
  assign dt_mag = dt[32] ? 33'(-dt) : 33'(dt);

  kvi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({el_mag[31:0], 16'd0}),
    .divisor  (dt_mag[31:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (comp)
      2'd0:    begin lerp_a = k0.x; lerp_b = k1.x; end
      2'd1:    begin lerp_a = k0.y; lerp_b = k1.y; end
      default: begin lerp_a = k0.z; lerp_b = k1.z; end
    endcase
  end

  assign lerp_req = '{start: (state == kvi_pkg::S_LERP) && lerp_go, fneg: fneg, mf: mf};

  kvi_lerp u_lerp (
    .clk       (clk),
    .rst       (rst),
    .req       (lerp_req),
    .start_val (lerp_a),
    .end_val   (lerp_b),
    .rsp       (lerp_rsp),
    .result    (lerp_res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign found    = qtime < rd_data.time_val;
  assign load_out = (state == kvi_pkg::S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    rd_addr    = pv_addr;
    div_start  = 1'b0;
    case (state)
      kvi_pkg::S_IDLE: begin
        if (accept && command == kvi_pkg::CMD_QUERY) begin
          if (n1 == '0) begin
            rd_addr    = '0;
            state_next = kvi_pkg::S_ONE;
          end else begin
            rd_addr    = AW'(1);
            state_next = kvi_pkg::S_SCAN;
          end
        end
      end
      kvi_pkg::S_ONE: state_next = kvi_pkg::S_DONE;
      kvi_pkg::S_SCAN: begin
        rd_addr = pv_addr + AW'(1);
        if (found || pv_addr == n1) begin
          state_next = kvi_pkg::S_FETCH0;
        end
      end
      kvi_pkg::S_FETCH0: begin
        rd_addr    = seg;
        state_next = kvi_pkg::S_FETCH1;
      end
      kvi_pkg::S_FETCH1: begin
        rd_addr    = seg + AW'(1);
        state_next = kvi_pkg::S_FETCH2;
      end
      kvi_pkg::S_FETCH2: state_next = kvi_pkg::S_PREP;
      kvi_pkg::S_PREP: begin
        if (dt == '0) begin
          state_next = kvi_pkg::S_LERP;
        end else begin
          div_start  = 1'b1;
          state_next = kvi_pkg::S_DIV;
        end
      end
      kvi_pkg::S_DIV:  if (div_done) state_next = kvi_pkg::S_LERP;
      kvi_pkg::S_LERP: if (lerp_rsp.done && comp == 2'd2) state_next = kvi_pkg::S_DONE;
      kvi_pkg::S_DONE: if (load_out) state_next = kvi_pkg::S_IDLE;
      default:         state_next = kvi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lerp_go   <= 1'b0;
      comp      <= '0;
      fault_acc <= 1'b0;
    end else begin
      case (state)
        kvi_pkg::S_IDLE: begin
          if (accept && command == kvi_pkg::CMD_QUERY) begin
            fault_acc <= 1'b0;
            comp      <= '0;
          end
        end
        kvi_pkg::S_PREP: begin
          lerp_go <= (dt == '0);
          if (dt == '0) fault_acc <= 1'b1;
        end
        kvi_pkg::S_DIV: if (div_done) lerp_go <= 1'b1;
        kvi_pkg::S_LERP: begin
          if (lerp_req.start) lerp_go <= 1'b0;
          if (lerp_rsp.done) begin
            fault_acc <= fault_acc | lerp_rsp.sat;
            if (comp != 2'd2) begin
              comp    <= comp + 2'd1;
              lerp_go <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      kvi_pkg::S_IDLE: begin
        if (accept && command == kvi_pkg::CMD_QUERY) begin
          qtime   <= query_time;
          pv_addr <= AW'(1);
          seg     <= '0;
        end
      end
      kvi_pkg::S_ONE: begin
        res_x <= rd_data.x;
        res_y <= rd_data.y;
        res_z <= rd_data.z;
      end
      kvi_pkg::S_SCAN: begin
        pv_addr <= pv_addr + AW'(1);
        if (found) seg <= pv_addr - AW'(1);
      end
      kvi_pkg::S_FETCH1: k0 <= rd_data;
      kvi_pkg::S_FETCH2: begin
        k1 <= rd_data;
        el <= signed'({1'b0, qtime}) - signed'({1'b0, k0.time_val});
        dt <= signed'({1'b0, rd_data.time_val}) - signed'({1'b0, k0.time_val});
      end
      kvi_pkg::S_PREP: begin
        mf   <= (el == '0) ? '0 : kvi_pkg::FACTOR_SAT;
        fneg <= el[32];
      end
      kvi_pkg::S_DIV: begin
        if (div_done) begin
          mf   <= kvi_pkg::FAC_W'(div_q);
          fneg <= el[32] ^ dt[32];
        end
      end
      kvi_pkg::S_LERP: begin
        if (lerp_rsp.done) begin
          case (comp)
            2'd0:    res_x <= lerp_res;
            2'd1:    res_y <= lerp_res;
            default: res_z <= lerp_res;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x   <= res_x;
      out_y   <= res_y;
      out_z   <= res_z;
      segment <= 8'(seg);
      fault   <= fault_acc;
    end
  end

  // Checks
  a_lerp_start_in_lerp: assert property (@(posedge clk) disable iff (rst)
    lerp_req.start |-> state == kvi_pkg::S_LERP)
    else $error("lerp started outside LERP");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == kvi_pkg::S_DIV)
    else $error("divider finished outside DIV");

  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    state == kvi_pkg::S_FETCH0 |-> seg < n1)
    else $error("segment beyond last key pair");

  a_query_stalls: assert property (@(posedge clk) disable iff (rst)
    (accept && command == kvi_pkg::CMD_QUERY) |=> in_stall)
    else $error("query accepted without stalling input");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !(out_valid && out_stall))
    else $error("output overwritten while stalled");

endmodule

// File: rtl/core/kvi_key_mem.sv
// ----------------------------------------------------------------------------
// kvi_key_mem
// Keyframe table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kvi_key_mem #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEFAULT,
  parameter int AW       = $clog2(MAX_KEYS)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  kvi_pkg::key_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output kvi_pkg::key_entry_t rd_data
);

  kvi_pkg::key_entry_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/kvi_divider.sv
// ----------------------------------------------------------------------------
// kvi_divider
// Restoring divider, one quotient bit per cycle: 48-bit by 32-bit unsigned.
// ----------------------------------------------------------------------------
module kvi_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [kvi_pkg::DVD_W-1:0] dividend,
  input  logic [31:0]               divisor,
  output logic                      done,
  output logic [kvi_pkg::DVD_W-1:0] quotient
);

  logic                          busy;
  logic [kvi_pkg::DIV_CNT_W-1:0] cnt;
  logic [31:0]                   rem;
  logic [32:0]                   shifted;
  logic [32:0]                   trial;

  assign shifted = {rem, quotient[kvi_pkg::DVD_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= kvi_pkg::DIV_CNT_W'(kvi_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == kvi_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[kvi_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[31:0];
        quotient <= {quotient[kvi_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/kvi_lerp.sv
// ----------------------------------------------------------------------------
// kvi_lerp
// One component: start + (end - start) * factor >> 16, saturated to 32 bits.
// Split multiply as a low and a high slice, then accumulate and saturate.
// ----------------------------------------------------------------------------
module kvi_lerp (
  input  logic                      clk,
  input  logic                      rst,
  input  kvi_pkg::lerp_req_t        req,
  input  logic signed [31:0]        start_val,
  input  logic signed [31:0]        end_val,
  output kvi_pkg::lerp_rsp_t        rsp,
  output logic signed [31:0]        result
);

  localparam int LO_PW = kvi_pkg::DIFF_W + kvi_pkg::FAC_LO;
  localparam int HI_PW = kvi_pkg::DIFF_W + kvi_pkg::FAC_W - kvi_pkg::FAC_LO;

  kvi_pkg::lerp_phase_t phase, phase_next;

  logic signed [31:0]                s0;
  logic signed [kvi_pkg::DIFF_W-1:0] diff;
  logic [kvi_pkg::DIFF_W-1:0]        md;
  logic [kvi_pkg::FAC_W-1:0]         mf;
  logic                              fsg;
  logic                              neg;
  logic [LO_PW-1:0]                  pp_lo;
  logic [HI_PW-1:0]                  pp_hi;
  logic [kvi_pkg::PRD_W-1:0]         acc;
  logic signed [48:0]                p49;
  logic signed [48:0]                sum;
  logic                              ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= kvi_pkg::LP_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      kvi_pkg::LP_IDLE: if (req.start) phase_next = kvi_pkg::LP_ABS;
      kvi_pkg::LP_ABS:  phase_next = kvi_pkg::LP_LO;
      kvi_pkg::LP_LO:   phase_next = kvi_pkg::LP_HI;
      kvi_pkg::LP_HI:   phase_next = kvi_pkg::LP_ACC;
      kvi_pkg::LP_ACC:  phase_next = kvi_pkg::LP_SAT;
      kvi_pkg::LP_SAT:  phase_next = kvi_pkg::LP_IDLE;
      default:          phase_next = kvi_pkg::LP_IDLE;
    endcase
  end

  assign ovf = |acc[kvi_pkg::PRD_W-1:63];
  assign p49 = signed'({2'b00, acc[62:16]});
  assign sum = neg ? (49'(s0) - p49) : (49'(s0) + p49);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp <= '0;
    end else begin
      rsp.done <= (phase == kvi_pkg::LP_SAT);
      if (phase == kvi_pkg::LP_SAT) begin
        rsp.sat <= ovf || (sum[48:31] != {18{sum[48]}});
      end
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      kvi_pkg::LP_IDLE: begin
        if (req.start) begin
          s0   <= start_val;
          diff <= kvi_pkg::DIFF_W'(end_val) - kvi_pkg::DIFF_W'(start_val);
          mf   <= req.mf;
          fsg  <= req.fneg;
        end
      end
      kvi_pkg::LP_ABS: begin
        md  <= diff[kvi_pkg::DIFF_W-1] ? kvi_pkg::DIFF_W'(-diff) : kvi_pkg::DIFF_W'(diff);
        neg <= diff[kvi_pkg::DIFF_W-1] ^ fsg;
      end
      kvi_pkg::LP_LO: pp_lo <= md * mf[kvi_pkg::FAC_LO-1:0];
      kvi_pkg::LP_HI: pp_hi <= md * mf[kvi_pkg::FAC_W-1:kvi_pkg::FAC_LO];
      kvi_pkg::LP_ACC: begin
        acc <= kvi_pkg::PRD_W'(pp_lo) + {pp_hi, {kvi_pkg::FAC_LO{1'b0}}};
      end
      kvi_pkg::LP_SAT: begin
        if (ovf) begin
          result <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (sum[48:31] != {18{sum[48]}}) begin
          result <= sum[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          result <= sum[31:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: bench/tb_keyframe_vec3_interpolator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_vec3_interpolator_core
// Loads keyframe tables, sets key_count over APB and checks interpolated
// vectors, segment and fault of every query against a behavioral lerp model.
// ----------------------------------------------------------------------------
module tb_keyframe_vec3_interpolator_core;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  idx;
    logic [31:0] kt;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic [31:0] qt;
  } beat_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  seg;
    logic        flt;
  } lerp_out_t;

  localparam int WATCHDOG = 200000;
  localparam int DRAIN = 400;
  localparam int LONG_HOLD = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [7:0] key_index = '0;
  logic [31:0] key_time = '0, query_time = '0;
  logic signed [31:0] key_x = '0, key_y = '0, key_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [7:0] segment;
  logic fault;

  keyframe_vec3_interpolator_core u_top (.*);

  always #5 clk = ~clk;

  beat_t     pending_beats[$];
  lerp_out_t expected_lerps[$];
  logic [31:0] time_mem[256];
  logic signed [31:0] vec_mem[256][3];
  int active_keys = 1;
  int errors = 0;
  int idle_cycles = 0;
  bit hold_send = 1'b0;
  bit long_req = 1'b0;
  int long_left = 0;
  bit in_taken = 1'b0;
  int burst_left = 0, gap_left = 0;

  function automatic logic signed [31:0] lerp_comp(longint s, longint d, longint f,
                                                   ref bit sat);
    longint unsigned md, mf, p;
    longint sum;
    bit neg;
    md = d < 0 ? -d : d;
    mf = f < 0 ? -f : f;
    neg = (d < 0) != (f < 0);
    if (md == 0 || mf == 0) return s[31:0];
    if (mf > 64'h7fffffffffffffff / md) begin
      sat = 1;
      return neg ? 32'sh80000000 : 32'sh7fffffff;
    end
    p = (md * mf) >> 16;
    sum = neg ? s - longint'(p) : s + longint'(p);
    if (sum > 64'sd2147483647) begin sat = 1; return 32'sh7fffffff; end
    if (sum < -64'sd2147483648) begin sat = 1; return 32'sh80000000; end
    return sum[31:0];
  endfunction

  task automatic apply_beat(beat_t b);
    lerp_out_t r;
    int seg, n;
    longint dt, el, f;
    longint unsigned qm;
    bit sat;
    sat = 0;
    if (b.cmd == kvi_pkg::CMD_WRITE) begin
      time_mem[b.idx] = b.kt;
      vec_mem[b.idx][0] = b.kx;
      vec_mem[b.idx][1] = b.ky;
      vec_mem[b.idx][2] = b.kz;
      return;
    end
    n = active_keys < 1 ? 1 : (active_keys > 256 ? 256 : active_keys);
    seg = 0;
    if (n == 1) begin
      r.x = vec_mem[0][0]; r.y = vec_mem[0][1]; r.z = vec_mem[0][2];
    end else begin
      for (int i = 0; i + 1 < n; i++)
        if (b.qt < time_mem[i+1]) begin seg = i; break; end
      dt = longint'({32'b0, time_mem[seg+1]}) - longint'({32'b0, time_mem[seg]});
      el = longint'({32'b0, b.qt}) - longint'({32'b0, time_mem[seg]});
      if (dt == 0) begin
        sat = 1;
        f = el > 0 ? (64'sd1 <<< 48) : (el < 0 ? -(64'sd1 <<< 48) : 0);
      end else begin
        qm = ((el < 0 ? -el : el) << 16) / (dt < 0 ? -dt : dt);
        f = ((el < 0) != (dt < 0)) ? -longint'(qm) : longint'(qm);
      end
      r.x = lerp_comp(vec_mem[seg][0], longint'(vec_mem[seg+1][0]) - vec_mem[seg][0], f, sat);
      r.y = lerp_comp(vec_mem[seg][1], longint'(vec_mem[seg+1][1]) - vec_mem[seg][1], f, sat);
      r.z = lerp_comp(vec_mem[seg][2], longint'(vec_mem[seg+1][2]) - vec_mem[seg][2], f, sat);
    end
    r.seg = seg[7:0];
    r.flt = sat;
    expected_lerps.push_back(r);
  endtask

  task automatic apb_write(logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    active_keys = v[8:0];
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_lerps.size() != 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic beat_t wr(int i, logic [31:0] t);
    beat_t b;
    b.cmd = kvi_pkg::CMD_WRITE; b.idx = 8'(i); b.kt = t;
    b.kx = $urandom; b.ky = $urandom; b.kz = $urandom; b.qt = $urandom;
    return b;
  endfunction

  function automatic beat_t qry(logic [31:0] t);
    beat_t b;
    b = wr(0, 0);
    b.cmd = kvi_pkg::CMD_QUERY; b.idx = 8'($urandom); b.kt = $urandom; b.qt = t;
    return b;
  endfunction

  // fill entries 0..n-1; mostly sorted, else random (mode 2: every third rising)
  task automatic load_table(int n, int mode);
    logic [31:0] t;
    beat_t b;
    t = $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      b = wr(i, mode == 0 ? t : $urandom);
      if (mode == 2 && i % 3 == 1) b.kt = t - 1;
      pending_beats.push_back(b);
      t = t + $urandom_range(1, 1 << $urandom_range(2, 20));
    end
  endtask

  // input accept as seen at the rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_taken) in_valid <= 1'b0;
      if (!(in_valid && !in_taken)) begin
        if (gap_left > 0) gap_left--;
        else if (!hold_send && pending_beats.size() != 0) begin
          beat_t b;
          b = pending_beats.pop_front();
          apply_beat(b);
          command <= b.cmd; key_index <= b.idx; key_time <= b.kt;
          key_x <= b.kx; key_y <= b.ky; key_z <= b.kz; query_time <= b.qt;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (long_req) begin
        long_left = LONG_HOLD;
        long_req = 1'b0;
      end
      out_stall <= (long_left > 0) || ($urandom_range(0, 3) == 0);
      if (long_left > 0) long_left--;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_lerps.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          lerp_out_t e;
          e = expected_lerps.pop_front();
          if (out_x !== e.x) begin $error("out_x exp %h got %h", e.x, out_x); errors++; end
          if (out_y !== e.y) begin $error("out_y exp %h got %h", e.y, out_y); errors++; end
          if (out_z !== e.z) begin $error("out_z exp %h got %h", e.z, out_z); errors++; end
          if (segment !== e.seg) begin
            $error("segment exp %0d got %0d", e.seg, segment); errors++;
          end
          if (fault !== e.flt) begin $error("fault exp %0d got %0d", e.flt, fault); errors++; end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    beat_t b;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // single key at reset count
    b = wr(0, 32'hffffffff); b.kx = 32'h7fffffff; b.ky = 32'h80000000; b.kz = 0;
    pending_beats.push_back(b);
    pending_beats.push_back(qry(0));
    pending_beats.push_back(qry(32'hffffffff));
    wait_idle();

    // directed: extremes, zero-length segment, unsorted, factor > 1
    apb_write(3);
    b = wr(0, 100); b.kx = 32'h80000000; b.ky = 0; b.kz = 5; pending_beats.push_back(b);
    b = wr(1, 100); b.kx = 32'h7fffffff; b.ky = 0; b.kz = 9; pending_beats.push_back(b);
    b = wr(2, 50);  b.kx = 32'h7fffffff; b.ky = 32'h80000000; b.kz = 1;
    pending_beats.push_back(b);
    pending_beats.push_back(qry(100));
    pending_beats.push_back(qry(99));
    pending_beats.push_back(qry(0));
    pending_beats.push_back(qry(32'hffffffff));
    pending_beats.push_back(qry(75));
    wait_idle();
    apb_write(2);
    b = wr(0, 0); b.kx = 0; b.ky = 32'h7fffffff; b.kz = 32'h80000000; pending_beats.push_back(b);
    b = wr(1, 32'hffffffff); b.kx = 32'hffffffff; b.ky = 32'h80000000; b.kz = 32'h7fffffff;
    pending_beats.push_back(b);
    pending_beats.push_back(qry(0));
    pending_beats.push_back(qry(32'h80000000));
    pending_beats.push_back(qry(32'hffffffff));
    wait_idle();
    apb_write(0);
    pending_beats.push_back(qry($urandom));
    wait_idle();

    // long output hold-off while the sender keeps offering
    apb_write(4);
    load_table(4, 0);
    for (int i = 0; i < 10; i++) pending_beats.push_back(qry($urandom_range(0, 1 << 20)));
    long_req = 1'b1;
    wait (!long_req);
    wait (long_left == 0);
    wait_idle();

    // full table and count above the table size
    apb_write(256);
    load_table(256, 0);
    for (int i = 0; i < 4; i++) pending_beats.push_back(qry($urandom));
    wait_idle();
    apb_write(511);
    pending_beats.push_back(qry($urandom));
    pending_beats.push_back(qry(32'hffffffff));
    wait_idle();

    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      apb_write(n);
      load_table(n, $urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : 0);
      for (int i = 0; i < 20; i++) begin
        case ($urandom_range(0, 9))
          0: pending_beats.push_back(qry($urandom));
          1: pending_beats.push_back(wr($urandom_range(0, n - 1), $urandom));
          default:
            pending_beats.push_back(qry(time_mem[0] + $urandom_range(0, 1 << 22)));
        endcase
      end
      if (ph == 2) begin
        hold_send = 1;
        while (expected_lerps.size() != 0) @(posedge clk);
        hold_send = 0;
      end
      wait_idle();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: keyframe_vec3_interpolator_core.f
rtl/core/kvi_pkg.sv
rtl/core/kvi_key_mem.sv
rtl/core/kvi_divider.sv
rtl/core/kvi_lerp.sv
rtl/core/keyframe_vec3_interpolator_core.sv
bench/tb_keyframe_vec3_interpolator_core.sv
